// ===== src/hdu_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-duplex 8N1 serial port: shared package
// Types, widths and codes that the channel interfaces and every module use.
// ----------------------------------------------------------------------------
package hdu_pkg;

    // Serial frame geometry.
    localparam int DATA_BITS  = 8;
    localparam int BIT_CNT_W  = $clog2(DATA_BITS + 3);

    // Field widths of the channels and of the configuration registers.
    localparam int CMD_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int TMO_W      = 16;
    localparam int BIT_TIME_W = 20;
    localparam int TRIM_W     = 16;
    localparam int TPM_W      = 18;
    localparam int CNT_W      = BIT_TIME_W + 1;
    localparam int ELAPSED_W  = TMO_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = BIT_TIME_W;

    // Command codes carried with each tick.
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RECV = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RX_TRIM      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [BIT_TIME_W-1:0] RST_BIT_TIME     = 20'd25000;
    localparam logic [TRIM_W-1:0]     RST_RX_TRIM      = 16'd500;
    localparam logic [TPM_W-1:0]      RST_TICKS_PER_MS = 18'd240000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TX,
        PH_RXWAIT,
        PH_RXDATA,
        PH_RXSTOP
    } t_phase;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] tx_byte;
        logic [TMO_W-1:0]  timeout_ms;
        logic              line_in;
    } t_in_item;

    typedef struct packed {
        logic              line_out;
        logic              busy_res;
        logic              rx_done;
        logic              rx_timed_out;
        logic [BYTE_W-1:0] rx_byte;
    } t_result;

    // Settings handed from the register bank to the bit engine.
    typedef struct packed {
        logic [BIT_TIME_W-1:0] bit_time;
        logic [TPM_W-1:0]      ticks_per_ms;
        logic [CNT_W-1:0]      first_wait;
    } t_cfg;

endpackage

// ===== src/hdu_if.sv =====
// ----------------------------------------------------------------------------
// Half-duplex 8N1 serial port: channel interfaces
// Valid/ready channels for ticks in, results out and register writes.
// ----------------------------------------------------------------------------
interface hdu_in_if;
    logic                        valid;
    logic                        ready;
    logic [hdu_pkg::CMD_W-1:0]   cmd;
    logic [hdu_pkg::BYTE_W-1:0]  tx_byte;
    logic [hdu_pkg::TMO_W-1:0]   timeout_ms;
    logic                        line_in;

    modport source (output valid, cmd, tx_byte, timeout_ms, line_in, input ready);
    modport sink   (input valid, cmd, tx_byte, timeout_ms, line_in, output ready);
endinterface

interface hdu_out_if;
    logic                        valid;
    logic                        ready;
    logic                        line_out;
    logic                        busy_res;
    logic                        rx_done;
    logic                        rx_timed_out;
    logic [hdu_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, line_out, busy_res, rx_done, rx_timed_out, rx_byte,
                    input ready);
    modport sink   (input valid, line_out, busy_res, rx_done, rx_timed_out, rx_byte,
                    output ready);
endinterface

interface hdu_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [hdu_pkg::CFG_IDX_W-1:0]   index;
    logic [hdu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/half_duplex_uart_8n1.sv =====
// ----------------------------------------------------------------------------
// Half-duplex 8N1 serial port: top level
// Bit-timed serial port that runs one send or one receive at a time.
// ----------------------------------------------------------------------------
// Every transaction on i_in is one tick of the bit timer. It carries a command
// (tick only, start send, start receive), the byte to send, the receive
// timeout in milliseconds and the sampled line level. Each accepted tick gives
// exactly one result transaction on o_out: the driven line level, the busy
// flag and, on the tick a receive ends, rx_done with the byte or a timeout.
// Commands arriving while a send or receive runs are ignored.
// Timing registers are written through i_cfg, which is always ready; writes
// belong in idle periods between operations.
// A tick is processed in the cycle it is accepted; its result is registered in
// the output register, or in the skid entry while the head waits. One tick is
// taken every cycle while i_in.ready is high; the engine updates once per tick.
// When the sink stalls, one further result is parked in a skid entry, after
// which i_in.ready drops until the sink takes a result.
// Reset restores the register defaults, returns the port to idle with the
// line high and empties the result queue.
// ----------------------------------------------------------------------------
module half_duplex_uart_8n1 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hdu_in_if.sink      i_in,
    hdu_cfg_if.sink     i_cfg,
    hdu_out_if.source   o_out
);

    hdu_pkg::t_cfg      cfg;
    hdu_pkg::t_in_item  item;
    hdu_pkg::t_result   result;
    logic               q_ready;
    logic               accept;

    // Intake stays open unless both result entries are occupied.
    assign i_in.ready = q_ready;
    assign accept     = i_in.valid && q_ready;

    assign item.cmd        = i_in.cmd;
    assign item.tx_byte    = i_in.tx_byte;
    assign item.timeout_ms = i_in.timeout_ms;
    assign item.line_in    = i_in.line_in;

    // Register bank; it also precomputes the first receive sample delay.
    hdu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Send and receive state, advanced once per accepted tick.
    hdu_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Output register plus skid entry towards the result sink.
    hdu_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_result (result),
        .o_ready  (q_ready),
        .o_out    (o_out)
    );

endmodule

// ===== src/hdu_cfg.sv =====
// ----------------------------------------------------------------------------
// Half-duplex 8N1 serial port: register bank
// Holds the timing registers and the derived first receive sample delay.
// ----------------------------------------------------------------------------
module hdu_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hdu_cfg_if.sink           i_cfg,
    output hdu_pkg::t_cfg     o_cfg
);

    // bt + bt/3 - trim, saturated at one. bt/3 is a multiply by the
    // reciprocal (2^21+1)/3, exact for every 20-bit bt.
    function automatic logic [hdu_pkg::CNT_W-1:0] first_wait_f(
        input logic [hdu_pkg::BIT_TIME_W-1:0] bt,
        input logic [hdu_pkg::TRIM_W-1:0]     trim
    );
        logic [40:0]                   prod;
        logic [hdu_pkg::CNT_W-1:0]     sum;
        logic [hdu_pkg::CNT_W-1:0]     trim_x;
        logic [hdu_pkg::CNT_W-1:0]     res;
        prod   = 41'(bt) * 41'd699051;
        sum    = hdu_pkg::CNT_W'(bt) + hdu_pkg::CNT_W'(prod[40:21]);
        trim_x = hdu_pkg::CNT_W'(trim);
        res    = (sum > trim_x) ? sum - trim_x : '0;
        if (res == '0) begin
            res = hdu_pkg::CNT_W'(1);
        end
        return res;
    endfunction

    logic [hdu_pkg::BIT_TIME_W-1:0] r_bit_time, n_bit_time;
    logic [hdu_pkg::TRIM_W-1:0]     r_trim, n_trim;
    logic [hdu_pkg::TPM_W-1:0]      r_tpm, n_tpm;
    logic [hdu_pkg::CNT_W-1:0]      r_first_wait, n_first_wait;
    logic                           wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_bit_time   = r_bit_time;
        n_trim       = r_trim;
        n_tpm        = r_tpm;
        if (wr) begin
            unique case (i_cfg.index)
                hdu_pkg::REG_BIT_TIME: begin
                    // A bit time of zero behaves as one.
                    n_bit_time = (i_cfg.data == '0) ? hdu_pkg::BIT_TIME_W'(1) : i_cfg.data;
                end
                hdu_pkg::REG_RX_TRIM: begin
                    n_trim = i_cfg.data[hdu_pkg::TRIM_W-1:0];
                end
                hdu_pkg::REG_TICKS_PER_MS: begin
                    n_tpm = (i_cfg.data[hdu_pkg::TPM_W-1:0] == '0) ?
                            hdu_pkg::TPM_W'(1) : i_cfg.data[hdu_pkg::TPM_W-1:0];
                end
                default: begin
                end
            endcase
        end
        n_first_wait = first_wait_f(n_bit_time, n_trim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_time   <= hdu_pkg::RST_BIT_TIME;
            r_trim       <= hdu_pkg::RST_RX_TRIM;
            r_tpm        <= hdu_pkg::RST_TICKS_PER_MS;
            r_first_wait <= first_wait_f(hdu_pkg::RST_BIT_TIME, hdu_pkg::RST_RX_TRIM);
        end else if (wr) begin
            r_bit_time   <= n_bit_time;
            r_trim       <= n_trim;
            r_tpm        <= n_tpm;
            r_first_wait <= n_first_wait;
        end
    end

    assign o_cfg.bit_time     = r_bit_time;
    assign o_cfg.ticks_per_ms = r_tpm;
    assign o_cfg.first_wait   = r_first_wait;

endmodule

// ===== src/hdu_core.sv =====
// ----------------------------------------------------------------------------
// Half-duplex 8N1 serial port: bit engine
// Advances the send/receive state by one clock tick per accepted transaction.
// ----------------------------------------------------------------------------
module hdu_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  hdu_pkg::t_in_item   i_item,
    input  hdu_pkg::t_cfg       i_cfg,
    output hdu_pkg::t_result    o_result
);

    localparam logic [hdu_pkg::BIT_CNT_W-1:0] DATA_BITS_C =
        hdu_pkg::BIT_CNT_W'(hdu_pkg::DATA_BITS);

    hdu_pkg::t_phase                   r_phase, n_phase;
    logic [hdu_pkg::BIT_CNT_W-1:0]     r_bit_count, n_bit_count;
    logic [hdu_pkg::CNT_W-1:0]         r_cycle_count, n_cycle_count;
    logic [hdu_pkg::BYTE_W-1:0]        r_shift, n_shift;
    logic [hdu_pkg::TPM_W-1:0]         r_ms_prescale, n_ms_prescale;
    logic [hdu_pkg::ELAPSED_W-1:0]     r_ms_elapsed, n_ms_elapsed;
    logic                              r_line_level, n_line_level;
    logic [hdu_pkg::TMO_W-1:0]         r_rx_limit, n_rx_limit;

    logic [hdu_pkg::CNT_W-1:0]         cnt_dec;
    logic [hdu_pkg::BIT_CNT_W-1:0]     bit_inc;
    logic [hdu_pkg::CNT_W-1:0]         bt_x;
    logic                              done;
    logic                              timed_out;
    logic [hdu_pkg::BYTE_W-1:0]        rxb;

    assign cnt_dec = r_cycle_count - hdu_pkg::CNT_W'(1);
    assign bit_inc = r_bit_count + hdu_pkg::BIT_CNT_W'(1);
    assign bt_x    = hdu_pkg::CNT_W'(i_cfg.bit_time);

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_cycle_count = r_cycle_count;
        n_shift       = r_shift;
        n_ms_prescale = r_ms_prescale;
        n_ms_elapsed  = r_ms_elapsed;
        n_line_level  = r_line_level;
        n_rx_limit    = r_rx_limit;
        done          = 1'b0;
        timed_out     = 1'b0;
        rxb           = '0;

        unique case (r_phase)
            hdu_pkg::PH_IDLE: begin
                if (i_item.cmd == hdu_pkg::CMD_SEND) begin
                    n_phase       = hdu_pkg::PH_TX;
                    n_bit_count   = '0;
                    n_cycle_count = bt_x;
                    n_shift       = i_item.tx_byte;
                    n_line_level  = 1'b0;
                end else if (i_item.cmd == hdu_pkg::CMD_RECV) begin
                    n_phase       = hdu_pkg::PH_RXWAIT;
                    n_ms_prescale = '0;
                    n_ms_elapsed  = '0;
                    n_shift       = '0;
                    n_rx_limit    = i_item.timeout_ms;
                end
            end
            hdu_pkg::PH_TX: begin
                n_cycle_count = cnt_dec;
                if (cnt_dec == '0) begin
                    n_bit_count   = bit_inc;
                    n_cycle_count = bt_x;
                    if (bit_inc <= DATA_BITS_C) begin
                        n_line_level = r_shift[0];
                        n_shift      = r_shift >> 1;
                    end else if (bit_inc == DATA_BITS_C + hdu_pkg::BIT_CNT_W'(1)) begin
                        n_line_level = 1'b1;
                    end else begin
                        n_phase       = hdu_pkg::PH_IDLE;
                        n_line_level  = 1'b1;
                        n_bit_count   = '0;
                        n_cycle_count = '0;
                    end
                end
            end
            hdu_pkg::PH_RXDATA: begin
                n_cycle_count = cnt_dec;
                if (cnt_dec == '0) begin
                    n_shift       = {i_item.line_in, r_shift[hdu_pkg::BYTE_W-1:1]};
                    n_bit_count   = bit_inc;
                    n_cycle_count = bt_x;
                    if (bit_inc >= DATA_BITS_C) begin
                        n_phase = hdu_pkg::PH_RXSTOP;
                    end
                end
            end
            hdu_pkg::PH_RXSTOP: begin
                n_cycle_count = cnt_dec;
                if (cnt_dec == '0) begin
                    n_phase     = hdu_pkg::PH_IDLE;
                    done        = 1'b1;
                    rxb         = r_shift;
                    n_bit_count = '0;
                end
            end
            hdu_pkg::PH_RXWAIT: begin
            end
            default: begin
            end
        endcase

        // The start-bit search also runs on the tick that takes the command.
        if (n_phase == hdu_pkg::PH_RXWAIT) begin
            if (!i_item.line_in) begin
                n_phase       = hdu_pkg::PH_RXDATA;
                n_bit_count   = '0;
                n_cycle_count = i_cfg.first_wait;
            end else begin
                n_ms_prescale = n_ms_prescale + hdu_pkg::TPM_W'(1);
                if (n_ms_prescale >= i_cfg.ticks_per_ms) begin
                    n_ms_prescale = '0;
                    n_ms_elapsed  = n_ms_elapsed + hdu_pkg::ELAPSED_W'(1);
                end
                if (n_ms_elapsed > hdu_pkg::ELAPSED_W'(n_rx_limit)) begin
                    n_phase   = hdu_pkg::PH_IDLE;
                    done      = 1'b1;
                    timed_out = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hdu_pkg::PH_IDLE;
            r_bit_count   <= '0;
            r_cycle_count <= '0;
            r_shift       <= '0;
            r_ms_prescale <= '0;
            r_ms_elapsed  <= '0;
            r_line_level  <= 1'b1;
            r_rx_limit    <= '0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_bit_count   <= n_bit_count;
            r_cycle_count <= n_cycle_count;
            r_shift       <= n_shift;
            r_ms_prescale <= n_ms_prescale;
            r_ms_elapsed  <= n_ms_elapsed;
            r_line_level  <= n_line_level;
            r_rx_limit    <= n_rx_limit;
        end
    end

    assign o_result.line_out     = n_line_level;
    assign o_result.busy_res     = (n_phase != hdu_pkg::PH_IDLE);
    assign o_result.rx_done      = done;
    assign o_result.rx_timed_out = timed_out;
    assign o_result.rx_byte      = rxb;

endmodule

// ===== src/hdu_outq.sv =====
// ----------------------------------------------------------------------------
// Half-duplex 8N1 serial port: result queue
// Output register with a skid entry so intake stalls only once both are full.
// ----------------------------------------------------------------------------
module hdu_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hdu_pkg::t_result   i_result,
    output logic               o_ready,
    hdu_out_if.source          o_out
);

    logic               r_head_valid, n_head_valid;
    logic               r_skid_valid, n_skid_valid;
    hdu_pkg::t_result   r_head, n_head;
    hdu_pkg::t_result   r_skid, n_skid;
    logic               pop;

    assign pop     = r_head_valid && o_out.ready;
    assign o_ready = !r_skid_valid;

    always_comb begin
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        n_head       = r_head;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_head_valid = i_push;
                n_head       = i_result;
            end
        end else if (i_push) begin
            if (!r_head_valid) begin
                n_head_valid = 1'b1;
                n_head       = i_result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_out.valid        = r_head_valid;
    assign o_out.line_out     = r_head.line_out;
    assign o_out.busy_res     = r_head.busy_res;
    assign o_out.rx_done      = r_head.rx_done;
    assign o_out.rx_timed_out = r_head.rx_timed_out;
    assign o_out.rx_byte      = r_head.rx_byte;

    // The skid entry is only ever filled behind a waiting head entry.
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry valid without head entry");

    // A push into a full head that is not drained lands in the skid entry.
    a_push_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_head_valid && !pop) |=> (r_skid_valid && r_skid == $past(i_result)))
        else $error("pushed result lost while head entry stalled");

    // With a skid entry waiting, a drained head is refilled from it.
    a_skid_to_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_skid_valid) |=> (r_head_valid && r_head == $past(r_skid)))
        else $error("skid entry not moved to head after drain");

endmodule
